// File: sv/trrb_pkg.sv
// Shared types and constants of the TCP receive reassembly buffer.
// No dependencies; the top, trrb_ctrl and trrb_dp import this package.
package trrb_pkg;

    localparam int unsigned COUNT_CAP    = 8191;
    localparam int unsigned RESULT_LIMIT = 4;

    typedef enum logic [1:0] {
        ACT_SEG  = 2'd0,
        ACT_READ = 2'd1,
        ACT_SACK = 2'd2,
        ACT_IGN  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_SEG  = 2'd0,
        KIND_READ = 2'd1,
        KIND_SACK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_OUTSIDE   = 2'd2
    } t_insert_status;

    typedef enum logic [1:0] {
        OUTC_NONE    = 2'd0,
        OUTC_STORING = 2'd1,
        OUTC_OUTSIDE = 2'd2,
        OUTC_EDGE    = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] segment_start;
        logic [7:0]  data_byte;
        logic        byte_present;
        logic        segment_last;
        logic [2:0]  max_blocks;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  insert_status;
        logic [31:0] next_expected;
        logic [12:0] fresh_count;
        logic [12:0] free_window;
        logic [7:0]  read_data;
        logic        read_valid;
        logic [31:0] blk_start;
        logic [31:0] blk_end;
        logic        last_result;
    } t_out_item;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_SEG_EVAL, S_SEG_WR, S_REP_PREP, S_ADV_RD, S_ADV_CHK,
        S_REP_PUSH, S_RD_ISSUE, S_RD_UPD, S_RD_PUSH, S_RD_EMPTY, S_SK_INIT,
        S_SK_RC, S_SK_RC_CHK, S_DN_RD, S_DN_CHK, S_UP_RD, S_UP_CHK, S_RC_END,
        S_SC_STEP, S_SC_CHK, S_SC_FOUND, S_SK_END
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR_STEP, OP_TAKE, OP_SEG_EVAL, OP_SEG_WR, OP_REP_PREP,
        OP_ADV_RD, OP_ADV_CHK, OP_SEG_CLEAR, OP_RD_ISSUE, OP_RD_UPD, OP_SK_INIT,
        OP_SK_RC, OP_DN_RD, OP_DN_CHK, OP_UP_RD, OP_UP_CHK, OP_RC_END,
        OP_SC_STEP, OP_SC_CHK, OP_SC_SET, OP_SC_SKIP
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   push;
        t_kind  kind;
        logic   rvalid;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic sk_ok;
        logic rc_ok;
        logic map_bit;
        logic dn_more;
        logic up_more;
        logic sc_more;
        logic dup;
        logic pend;
        logic seg_store;
        logic adv;
        logic adv_more;
        logic rd_empty;
        logic clr_done;
    } t_dp_status;

endpackage

// File: sv/tcp_receive_reassembly_buffer_top.sv
// A segment byte is evaluated and, when it is stored, written. The last item of a segment
// then advances the next expected sequence across any received bytes and reports. A read
// issues, updates the pointers and pushes, or pushes at once when no byte is in order.
// A SACK request walks the receipt map. Each push also waits for a held result to leave.
// Synchronous active-low reset; after reset and after each configuration write the
// receipt map is cleared one slot at a time, during which no item is taken.
module tcp_receive_reassembly_buffer_top #(
    parameter int BUFFER_BYTES    = 4096,
    parameter int MAX_SACK_BLOCKS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  trrb_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output trrb_pkg::t_out_item o_out_data
);
    import trrb_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    trrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_present  (i_in_data.byte_present),
        .i_last     (i_in_data.segment_last),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    trrb_dp #(
        .BUFFER_BYTES    (BUFFER_BYTES),
        .MAX_SACK_BLOCKS (MAX_SACK_BLOCKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("item taken during the clearing pass after reset");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_in_ready)
        else $error("item taken during the clearing pass after a configuration write");

    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action == ACT_READ |=> !o_in_ready)
        else $error("read transfer did not occupy the block");
endmodule

// File: sv/trrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module trrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// File: sv/trrb_ctrl.sv
// Sequencing state machine of the reassembly buffer.
// Depends on trrb_pkg; drives the datapath through t_dp_cmd and reads t_dp_status.
module trrb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_action,
    input  logic                 i_present,
    input  logic                 i_last,
    output logic                 o_in_ready,
    output trrb_pkg::t_dp_cmd    o_cmd,
    input  trrb_pkg::t_dp_status i_status
);
    import trrb_pkg::*;

    t_state r_state, n_state;
    logic   r_mode, n_mode;
    logic   r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_mode  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_last  = r_last;
        case (r_state)
            S_CLEAR: begin
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_last;
                    case (i_action)
                        ACT_SEG: begin
                            if (i_present) n_state = S_SEG_EVAL;
                            else if (i_last) n_state = S_REP_PREP;
                        end
                        ACT_READ: n_state = S_RD_ISSUE;
                        ACT_SACK: n_state = S_SK_INIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_SEG_EVAL: begin
                if (i_status.seg_store) n_state = S_SEG_WR;
                else n_state = r_last ? S_REP_PREP : S_IDLE;
            end
            S_SEG_WR:   n_state = r_last ? S_REP_PREP : S_IDLE;
            S_REP_PREP: n_state = i_status.adv ? S_ADV_RD : S_REP_PUSH;
            S_ADV_RD:   n_state = i_status.adv_more ? S_ADV_CHK : S_REP_PUSH;
            S_ADV_CHK:  n_state = i_status.map_bit ? S_ADV_RD : S_REP_PUSH;
            S_REP_PUSH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_RD_ISSUE: n_state = i_status.rd_empty ? S_RD_EMPTY : S_RD_UPD;
            S_RD_UPD:   n_state = S_RD_PUSH;
            S_RD_PUSH, S_RD_EMPTY: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            S_SK_INIT:  n_state = i_status.sk_ok ? S_SK_RC : S_SK_END;
            S_SK_RC:    n_state = i_status.rc_ok ? S_SK_RC_CHK : S_SC_STEP;
            S_SK_RC_CHK: begin
                n_mode  = 1'b0;
                n_state = i_status.map_bit ? S_DN_RD : S_SC_STEP;
            end
            S_DN_RD: begin
                if (i_status.dn_more) n_state = S_DN_CHK;
                else n_state = r_mode ? S_SC_FOUND : S_UP_RD;
            end
            S_DN_CHK: begin
                if (i_status.map_bit) n_state = S_DN_RD;
                else n_state = r_mode ? S_SC_FOUND : S_UP_RD;
            end
            S_UP_RD:    n_state = i_status.up_more ? S_UP_CHK : S_RC_END;
            S_UP_CHK:   n_state = i_status.map_bit ? S_UP_RD : S_RC_END;
            S_RC_END:   n_state = S_SC_STEP;
            S_SC_STEP:  n_state = i_status.sc_more ? S_SC_CHK : S_SK_END;
            S_SC_CHK: begin
                n_mode  = 1'b1;
                n_state = i_status.map_bit ? S_DN_RD : S_SC_STEP;
            end
            S_SC_FOUND: begin
                if (i_status.dup || !i_status.pend || i_status.out_free) begin
                    n_state = S_SC_STEP;
                end
            end
            S_SK_END: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_CLEAR;
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.op     = OP_NOP;
        o_cmd.push   = 1'b0;
        o_cmd.kind   = KIND_SEG;
        o_cmd.rvalid = 1'b0;
        o_cmd.last   = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.op = OP_CLR_STEP;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_TAKE;
            end
            S_SEG_EVAL: o_cmd.op = OP_SEG_EVAL;
            S_SEG_WR:   o_cmd.op = OP_SEG_WR;
            S_REP_PREP: o_cmd.op = OP_REP_PREP;
            S_ADV_RD:   o_cmd.op = OP_ADV_RD;
            S_ADV_CHK:  o_cmd.op = OP_ADV_CHK;
            S_REP_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.op   = OP_SEG_CLEAR;
                    o_cmd.push = 1'b1;
                    o_cmd.kind = KIND_SEG;
                    o_cmd.last = 1'b1;
                end
            end
            S_RD_ISSUE: o_cmd.op = OP_RD_ISSUE;
            S_RD_UPD:   o_cmd.op = OP_RD_UPD;
            S_RD_PUSH, S_RD_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.kind   = KIND_READ;
                    o_cmd.rvalid = (r_state == S_RD_PUSH);
                    o_cmd.last   = 1'b1;
                end
            end
            S_SK_INIT: o_cmd.op = OP_SK_INIT;
            S_SK_RC:   o_cmd.op = OP_SK_RC;
            S_DN_RD:   o_cmd.op = OP_DN_RD;
            S_DN_CHK:  o_cmd.op = OP_DN_CHK;
            S_UP_RD:   o_cmd.op = OP_UP_RD;
            S_UP_CHK:  o_cmd.op = OP_UP_CHK;
            S_RC_END:  o_cmd.op = OP_RC_END;
            S_SC_STEP: o_cmd.op = OP_SC_STEP;
            S_SC_CHK:  o_cmd.op = OP_SC_CHK;
            S_SC_FOUND: begin
                if (i_status.dup) begin
                    o_cmd.op = OP_SC_SKIP;
                end else if (!i_status.pend) begin
                    o_cmd.op = OP_SC_SET;
                end else if (i_status.out_free) begin
                    o_cmd.op   = OP_SC_SET;
                    o_cmd.push = 1'b1;
                    o_cmd.kind = KIND_SACK;
                end
            end
            S_SK_END: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = i_status.pend ? KIND_SACK : KIND_NONE;
                    o_cmd.last = 1'b1;
                end
            end
            default: o_cmd.op = OP_NOP;
        endcase
    end
endmodule

// File: sv/trrb_dp.sv
// Datapath of the reassembly buffer: pointers, segment state, SACK scan registers,
// byte store and receipt map RAMs, and the output register. Depends on trrb_pkg, trrb_ram.
module trrb_dp #(
    parameter int BUFFER_BYTES    = 4096,
    parameter int MAX_SACK_BLOCKS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  trrb_pkg::t_in_item   i_in_data,
    input  trrb_pkg::t_dp_cmd    i_cmd,
    output trrb_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output trrb_pkg::t_out_item  o_out_data
);
    import trrb_pkg::*;

    localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int OW = $clog2(BUFFER_BYTES + 1);
    localparam int LIM_CAP = (MAX_SACK_BLOCKS < RESULT_LIMIT) ? MAX_SACK_BLOCKS : RESULT_LIMIT;
    localparam logic [31:0]   BUF32  = 32'(BUFFER_BYTES);
    localparam logic [OW-1:0] BUF_O  = OW'(BUFFER_BYTES);
    localparam logic [AW:0]   BUF_A1 = (AW + 1)'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_SLOT = AW'(BUFFER_BYTES - 1);
    localparam logic [2:0]    LIM3 = 3'(LIM_CAP);

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= BUF_A1) sum = sum - BUF_A1;
        return sum[AW-1:0];
    endfunction

    t_in_item        r_item;
    logic [31:0]     r_rd, r_exp, r_recent, r_idx, r_first_new, r_seq;
    logic            r_recent_valid;
    logic [AW-1:0]   r_head, r_p, r_clr;
    logic [12:0]     r_cnt;
    t_outcome        r_outcome;
    t_insert_status  r_status;
    logic [OW-1:0]   r_first, r_cur, r_blo, r_bhi, r_plo, r_phi, r_rlo, r_rhi;
    logic [2:0]      r_limit, r_sk_cnt;
    logic            r_pend, r_have_recent;
    t_out_item       r_out;
    logic            r_out_valid;

    logic [31:0]     used, free32, seq, off, rc_off;
    logic [12:0]     free13;
    logic            early, trimmed, in_win, seg_store;
    t_outcome        outc;
    t_insert_status  stat_c;
    logic [2:0]      limit_c;
    logic [OW-1:0]   dn_off, cur_dec;
    logic            map_q;
    logic [7:0]      byte_q;
    logic            map_we, map_wdata, byte_we, byte_re;
    logic [AW-1:0]   map_waddr, map_raddr;
    logic            out_free;
    t_out_item       payload;

    assign used   = r_exp - r_rd;
    assign free32 = BUF32 - used;
    assign free13 = (free32 > 32'(COUNT_CAP)) ? 13'(COUNT_CAP) : free32[12:0];

    assign seq     = r_item.segment_start + r_idx;
    assign early   = ((r_item.segment_start - r_exp) >> 31) != 32'd0;
    assign trimmed = early && (r_idx < (r_exp - r_item.segment_start));
    assign off     = seq - r_rd;
    assign in_win  = off < BUF32;
    assign outc    = (r_outcome == OUTC_NONE) ? (in_win ? OUTC_STORING : OUTC_OUTSIDE)
                                              : r_outcome;
    assign seg_store = !trimmed && (outc == OUTC_STORING) && in_win;

    always_comb begin
        if (r_outcome == OUTC_OUTSIDE) stat_c = ST_OUTSIDE;
        else if (r_outcome == OUTC_NONE) stat_c = ST_DUPLICATE;
        else if (r_cnt != 13'd0) stat_c = ST_ACCEPTED;
        else stat_c = ST_DUPLICATE;
    end

    assign limit_c = (r_item.max_blocks < LIM3) ? r_item.max_blocks : LIM3;
    assign rc_off  = r_recent - r_rd;
    assign dn_off  = r_blo - OW'(1);
    assign cur_dec = r_cur - OW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.out_free  = out_free;
    assign o_status.sk_ok     = (limit_c != 3'd0) && (used < BUF32);
    assign o_status.rc_ok     = r_recent_valid && (rc_off >= 32'(r_first)) && (rc_off < BUF32);
    assign o_status.map_bit   = map_q;
    assign o_status.dn_more   = r_blo > r_first;
    assign o_status.up_more   = r_bhi < BUF_O;
    assign o_status.sc_more   = (r_cur > r_first) && (r_sk_cnt < r_limit);
    assign o_status.dup       = r_have_recent && (r_blo == r_rlo) && (r_bhi == r_rhi);
    assign o_status.pend      = r_pend;
    assign o_status.seg_store = seg_store;
    assign o_status.adv       = r_outcome[0];
    assign o_status.adv_more  = used < BUF32;
    assign o_status.rd_empty  = r_exp == r_rd;
    assign o_status.clr_done  = r_clr == LAST_SLOT;

    always_comb begin
        map_raddr = '0;
        map_we    = 1'b0;
        map_waddr = r_clr;
        map_wdata = 1'b0;
        case (i_cmd.op)
            OP_SEG_EVAL: map_raddr = f_slot(r_head, off[AW-1:0]);
            OP_ADV_RD:   map_raddr = f_slot(r_head, used[AW-1:0]);
            OP_SK_RC:    map_raddr = f_slot(r_head, rc_off[AW-1:0]);
            OP_DN_RD:    map_raddr = f_slot(r_head, dn_off[AW-1:0]);
            OP_UP_RD:    map_raddr = f_slot(r_head, r_bhi[AW-1:0]);
            OP_SC_STEP:  map_raddr = f_slot(r_head, cur_dec[AW-1:0]);
            default:     map_raddr = '0;
        endcase
        case (i_cmd.op)
            OP_CLR_STEP: map_we = 1'b1;
            OP_SEG_WR: begin
                map_we    = !map_q;
                map_waddr = r_p;
                map_wdata = 1'b1;
            end
            OP_RD_UPD: begin
                map_we    = 1'b1;
                map_waddr = r_head;
            end
            default: map_we = 1'b0;
        endcase
    end

    assign byte_we = (i_cmd.op == OP_SEG_WR) && !map_q;
    assign byte_re = (i_cmd.op == OP_RD_ISSUE);

    trrb_ram #(.WIDTH(1), .DEPTH(BUFFER_BYTES)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (1'b1),
        .i_raddr (map_raddr),
        .o_rdata (map_q)
    );

    trrb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (r_p),
        .i_wdata (r_item.data_byte),
        .i_re    (byte_re),
        .i_raddr (r_head),
        .o_rdata (byte_q)
    );

    always_comb begin
        payload.result_kind   = i_cmd.kind;
        payload.insert_status = (i_cmd.kind == KIND_SEG) ? r_status : 2'd0;
        payload.next_expected = r_exp;
        payload.fresh_count   = ((i_cmd.kind == KIND_SEG) && (r_status != ST_OUTSIDE))
                                ? r_cnt : 13'd0;
        payload.free_window   = free13;
        payload.read_valid    = (i_cmd.kind == KIND_READ) && i_cmd.rvalid;
        payload.read_data     = payload.read_valid ? byte_q : 8'd0;
        payload.blk_start     = (i_cmd.kind == KIND_SACK) ? r_rd + 32'(r_plo) : 32'd0;
        payload.blk_end       = (i_cmd.kind == KIND_SACK) ? r_rd + 32'(r_phi) : 32'd0;
        payload.last_result   = i_cmd.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd           <= '0;
            r_exp          <= '0;
            r_head         <= '0;
            r_recent       <= '0;
            r_recent_valid <= 1'b0;
            r_idx          <= '0;
            r_cnt          <= '0;
            r_first_new    <= '0;
            r_outcome      <= OUTC_NONE;
            r_clr          <= '0;
        end else if (i_cfg_we) begin
            r_rd           <= i_cfg_wdata;
            r_exp          <= i_cfg_wdata;
            r_head         <= '0;
            r_recent       <= '0;
            r_recent_valid <= 1'b0;
            r_idx          <= '0;
            r_cnt          <= '0;
            r_first_new    <= '0;
            r_outcome      <= OUTC_NONE;
            r_clr          <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLR_STEP: r_clr <= (r_clr == LAST_SLOT) ? '0 : r_clr + AW'(1);
                OP_SEG_EVAL: begin
                    r_idx <= r_idx + 32'd1;
                    if (!trimmed) begin
                        r_outcome <= (outc == OUTC_STORING && !in_win) ? OUTC_EDGE : outc;
                    end
                end
                OP_SEG_WR: begin
                    if (!map_q) begin
                        if (r_cnt == 13'd0) r_first_new <= r_seq;
                        if (r_cnt < 13'(COUNT_CAP)) r_cnt <= r_cnt + 13'd1;
                    end
                end
                OP_REP_PREP: begin
                    if (r_outcome[0] && r_cnt != 13'd0) begin
                        r_recent       <= r_first_new;
                        r_recent_valid <= 1'b1;
                    end
                end
                OP_ADV_CHK: begin
                    if (map_q) r_exp <= r_exp + 32'd1;
                end
                OP_SEG_CLEAR: begin
                    r_idx       <= '0;
                    r_cnt       <= '0;
                    r_first_new <= '0;
                    r_outcome   <= OUTC_NONE;
                end
                OP_RD_UPD: begin
                    r_head <= (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                    r_rd   <= r_rd + 32'd1;
                end
                default: r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) r_out <= payload;
        case (i_cmd.op)
            OP_TAKE: r_item <= i_in_data;
            OP_SEG_EVAL: begin
                r_p   <= f_slot(r_head, off[AW-1:0]);
                r_seq <= seq;
            end
            OP_REP_PREP: r_status <= stat_c;
            OP_SK_INIT: begin
                r_first       <= used[OW-1:0];
                r_limit       <= limit_c;
                r_sk_cnt      <= '0;
                r_pend        <= 1'b0;
                r_have_recent <= 1'b0;
                r_cur         <= BUF_O;
            end
            OP_SK_RC: begin
                r_blo <= rc_off[OW-1:0];
                r_bhi <= rc_off[OW-1:0] + OW'(1);
            end
            OP_DN_CHK: begin
                if (map_q) r_blo <= dn_off;
            end
            OP_UP_CHK: begin
                if (map_q) r_bhi <= r_bhi + OW'(1);
            end
            OP_RC_END: begin
                r_plo         <= r_blo;
                r_phi         <= r_bhi;
                r_rlo         <= r_blo;
                r_rhi         <= r_bhi;
                r_have_recent <= 1'b1;
                r_pend        <= 1'b1;
                r_sk_cnt      <= 3'd1;
            end
            OP_SC_STEP: begin
                if (o_status.sc_more) r_cur <= cur_dec;
            end
            OP_SC_CHK: begin
                if (map_q) begin
                    r_blo <= r_cur;
                    r_bhi <= r_cur + OW'(1);
                end
            end
            OP_SC_SET: begin
                r_cur    <= r_blo;
                r_plo    <= r_blo;
                r_phi    <= r_bhi;
                r_pend   <= 1'b1;
                r_sk_cnt <= r_sk_cnt + 3'd1;
            end
            OP_SC_SKIP: r_cur <= r_blo;
            default: r_cur <= r_cur;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
